// ----- hdl/stxyz_pkg.sv -----
// stxyz_pkg: shared types, constants and color-matching weight tables for the
// 32-band spectrum to XYZ converter. No dependencies.
`timescale 1ns / 1ps

package stxyz_pkg;

   localparam int BAND_COUNT   = 32;
   localparam int BAND_WIDTH   = 5;
   localparam int WEIGHT_WIDTH = 15;
   localparam int ACC_WIDTH    = 48;
   localparam int OUT_WIDTH    = 24;
   localparam int SCALE_WIDTH  = 13;
   localparam int ROUND_SHIFT  = 30;

   // reciprocal of the luminance integral 11.2964057, Q0.16
   localparam logic [SCALE_WIDTH-1:0] INV_YINT_Q16 = 13'd5801;

   localparam logic [BAND_WIDTH-1:0] LAST_BAND = 5'd31;

   typedef enum logic [1:0] {
      CH_X = 2'd0,
      CH_Y = 2'd1,
      CH_Z = 2'd2
   } channel_type;

   // stage enables shared by the three lanes
   typedef struct packed {
      logic b_load;
      logic acc_update;
      logic last;
      logic c_load;
      logic d_load;
      logic e_load;
   } ctrl_type;

   localparam logic [WEIGHT_WIDTH-1:0] CMF_X [BAND_COUNT] = '{
      15'd62,    15'd363,   15'd1467,  15'd3335,  15'd4781,  15'd5706,  15'd5283,
      15'd4072,  15'd2960,  15'd1341,  15'd341,   15'd40,    15'd255,   15'd1305,
      15'd2979,  15'd5076,  15'd7363,  15'd10050, 15'd13054, 15'd15792, 15'd18182,
      15'd18859, 15'd17759, 15'd14980, 15'd11345, 15'd7752,  15'd4911,  15'd2798,
      15'd1511,  15'd772,   15'd371,   15'd180
   };

   localparam logic [WEIGHT_WIDTH-1:0] CMF_Y [BAND_COUNT] = '{
      15'd7,     15'd40,    15'd149,   15'd332,   15'd544,   15'd825,   15'd1060,
      15'd1395,  15'd2128,  15'd2930,  15'd3898,  15'd5707,  15'd8528,  15'd11765,
      15'd14051, 15'd15638, 15'd16204, 15'd16331, 15'd15946, 15'd14686, 15'd13298,
      15'd11335, 15'd9148,  15'd6930,  15'd4884,  15'd3184,  15'd1955,  15'd1093,
      15'd583,   15'd296,   15'd142,   15'd69
   };

   localparam logic [WEIGHT_WIDTH-1:0] CMF_Z [BAND_COUNT] = '{
      15'd303,   15'd1796,  15'd7387,  15'd17233, 15'd25442, 15'd31416, 15'd30287,
      15'd24939, 15'd20490, 15'd12374, 15'd6716,  15'd3894,  15'd1928,  15'd926,
      15'd399,   15'd161,   15'd62,    15'd23,    15'd9,     15'd3,     15'd1,
      15'd1,     15'd0,     15'd0,     15'd0,     15'd0,     15'd0,     15'd0,
      15'd0,     15'd0,     15'd0,     15'd0
   };

   function automatic logic [WEIGHT_WIDTH-1:0] cmf_weight(input channel_type ch,
                                                          input logic [BAND_WIDTH-1:0] band);
      logic [WEIGHT_WIDTH-1:0] w;
      case (ch)
         CH_X:    w = CMF_X[band];
         CH_Y:    w = CMF_Y[band];
         CH_Z:    w = CMF_Z[band];
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/stxyz_req_if.sv -----
// stxyz_req_if: sample channel, valid/ready with one signed spectral sample.
// Depends on nothing.
`timescale 1ns / 1ps

interface stxyz_req_if #(
   parameter int SAMPLE_WIDTH = 24
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ----- hdl/stxyz_rsp_if.sv -----
// stxyz_rsp_if: result channel, valid/ready with one XYZ triple.
// Widths from stxyz_pkg.
`timescale 1ns / 1ps

interface stxyz_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [stxyz_pkg::OUT_WIDTH-1:0]   x_value;
   logic signed [stxyz_pkg::OUT_WIDTH-1:0]   y_value;
   logic signed [stxyz_pkg::OUT_WIDTH-1:0]   z_value;

   modport source (output valid, output x_value, output y_value, output z_value, input ready);
   modport sink   (input valid, input x_value, input y_value, input z_value, output ready);
endinterface

// ----- hdl/spectrum_to_xyz_32band_top.sv -----
// spectrum_to_xyz_32band_top: band counter, stage handshake and three XYZ lanes.
// Uses stxyz_pkg, stxyz_req_if, stxyz_rsp_if and stxyz_lane.
`timescale 1ns / 1ps
//
//   channel   dir   port     payload                         per word
//   -------   ---   ------   -----------------------------   ---------------------
//   samples   in    req_ch   sample (signed Q8.16)           one band, first band first
//   results   out   rsp_ch   x_value, y_value, z_value       one XYZ per 32 samples
//
// one sample is taken every cycle while rsp_ch does not stall; the five register
// stages (input, product, accumulate, scale, output) each hold one word. after its
// 32nd sample is taken, the result of a spectrum passes through the product,
// accumulate and scale stages into the output register and can be taken on the
// next edge. reset clears the band counter, the accumulators and all stage
// valids. a stall on rsp_ch fills the empty stages first, then holds req_ch.

module spectrum_to_xyz_32band_top #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic         clock,
   input  logic         reset,
   stxyz_req_if.sink    req_ch,
   stxyz_rsp_if.source  rsp_ch
);

   localparam int BAND_WIDTH = stxyz_pkg::BAND_WIDTH;

   stxyz_pkg::ctrl_type ctrl;

   logic [BAND_WIDTH-1:0]          band_in, band_ff;
   logic                           a_valid_in, a_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] a_sample_ff;
   logic [BAND_WIDTH-1:0]          a_band_ff;
   logic                           b_valid_in, b_valid_ff;
   logic                           b_last_ff;
   logic                           c_valid_in, c_valid_ff;
   logic                           d_valid_in, d_valid_ff;
   logic                           rsp_valid_in, rsp_valid_ff;

   logic a_load, a_ready, b_ready, b_adv, c_ready, d_ready, e_ready;

   // ready runs back from the output register through each stage
   assign e_ready = ~rsp_valid_ff | rsp_ch.ready;
   assign d_ready = ~d_valid_ff | e_ready;
   assign c_ready = ~c_valid_ff | d_ready;
   // only the last band of a spectrum needs room downstream
   assign b_adv   = b_valid_ff & (~b_last_ff | c_ready);
   assign b_ready = ~b_valid_ff | b_adv;
   assign a_ready = ~a_valid_ff | b_ready;
   assign a_load  = req_ch.valid & a_ready;

   assign ctrl.b_load     = a_valid_ff & b_ready;
   assign ctrl.acc_update = b_adv;
   assign ctrl.last       = b_last_ff;
   assign ctrl.c_load     = b_adv & b_last_ff;
   assign ctrl.d_load     = c_valid_ff & d_ready;
   assign ctrl.e_load     = d_valid_ff & e_ready;

   assign band_in      = a_load ? band_ff + BAND_WIDTH'(1) : band_ff;
   assign a_valid_in   = a_load | (a_valid_ff & ~b_ready);
   assign b_valid_in   = ctrl.b_load | (b_valid_ff & ~b_adv);
   assign c_valid_in   = ctrl.c_load | (c_valid_ff & ~d_ready);
   assign d_valid_in   = ctrl.d_load | (d_valid_ff & ~e_ready);
   assign rsp_valid_in = ctrl.e_load | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff      <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         band_ff      <= band_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_sample_ff <= req_ch.sample;
         a_band_ff   <= band_ff;
      end
      if (ctrl.b_load) begin
         b_last_ff <= (a_band_ff == stxyz_pkg::LAST_BAND);
      end
   end

   stxyz_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CHANNEL(stxyz_pkg::CH_X)) u_lane_x (
      .clock(clock), .reset(reset), .ctrl(ctrl),
      .sample(a_sample_ff), .band(a_band_ff), .result(rsp_ch.x_value)
   );

   stxyz_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CHANNEL(stxyz_pkg::CH_Y)) u_lane_y (
      .clock(clock), .reset(reset), .ctrl(ctrl),
      .sample(a_sample_ff), .band(a_band_ff), .result(rsp_ch.y_value)
   );

   stxyz_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CHANNEL(stxyz_pkg::CH_Z)) u_lane_z (
      .clock(clock), .reset(reset), .ctrl(ctrl),
      .sample(a_sample_ff), .band(a_band_ff), .result(rsp_ch.z_value)
   );

   assign req_ch.ready = a_ready;
   assign rsp_ch.valid = rsp_valid_ff;

   // band counter wraps to the first band after the last one is taken
   assert property (@(posedge clock) disable iff (reset)
      a_load && band_ff == stxyz_pkg::LAST_BAND |=> band_ff == '0)
      else $error("band counter did not wrap after last band");

   // an empty input stage never holds off the sample channel
   assert property (@(posedge clock) disable iff (reset)
      !a_valid_ff |-> req_ch.ready)
      else $error("input stage empty but not ready");

   // a finished spectrum always lands in the accumulate stage
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_last_ff && ctrl.acc_update |=> c_valid_ff)
      else $error("last band consumed without a finished sum");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !a_valid_ff && !b_valid_ff && !c_valid_ff && !d_valid_ff && !rsp_valid_ff)
      else $error("stage valid set after reset");

endmodule

// ----- hdl/stxyz_lane.sv -----
// stxyz_lane: one tristimulus channel: weight multiply, saturating accumulate,
// reciprocal scale, round and saturate. Uses stxyz_pkg; stage enables from the top.
`timescale 1ns / 1ps

module stxyz_lane #(
   parameter int                      SAMPLE_WIDTH = 24,
   parameter stxyz_pkg::channel_type  CHANNEL      = stxyz_pkg::CH_X
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  stxyz_pkg::ctrl_type                    ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0]         sample,
   input  logic [stxyz_pkg::BAND_WIDTH-1:0]       band,
   output logic signed [stxyz_pkg::OUT_WIDTH-1:0] result
);

   localparam int PROD_WIDTH   = SAMPLE_WIDTH + stxyz_pkg::WEIGHT_WIDTH + 1;
   localparam int ACC_WIDTH    = stxyz_pkg::ACC_WIDTH;
   localparam int SCALED_WIDTH = ACC_WIDTH + stxyz_pkg::SCALE_WIDTH + 1;
   localparam int QUOT_WIDTH   = SCALED_WIDTH - stxyz_pkg::ROUND_SHIFT;
   localparam int OUT_WIDTH    = stxyz_pkg::OUT_WIDTH;

   localparam logic [SCALED_WIDTH-1:0] ROUND_BIAS =
      SCALED_WIDTH'(64'd1 << (stxyz_pkg::ROUND_SHIFT - 1));
   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   logic [stxyz_pkg::WEIGHT_WIDTH-1:0] weight;
   logic signed [PROD_WIDTH-1:0]       prod_in, prod_ff;
   logic signed [ACC_WIDTH:0]          acc_wide;
   logic signed [ACC_WIDTH-1:0]        acc_sat;
   logic signed [ACC_WIDTH-1:0]        acc_in, acc_ff;
   logic signed [ACC_WIDTH-1:0]        sum_in, sum_ff;
   logic signed [SCALED_WIDTH-1:0]     scaled_in, scaled_ff;
   logic [SCALED_WIDTH-1:0]            rounded;
   logic [QUOT_WIDTH-1:0]              quot;
   logic                               quot_fits;
   logic signed [OUT_WIDTH-1:0]        out_in, out_ff;

   // stage b: weight product, Q.30
   assign weight  = stxyz_pkg::cmf_weight(CHANNEL, band);
   assign prod_in = sample * $signed({1'b0, weight});

   // accumulate with saturation at the 48-bit bounds
   assign acc_wide = {acc_ff[ACC_WIDTH-1], acc_ff}
                   + {{(ACC_WIDTH + 1 - PROD_WIDTH){prod_ff[PROD_WIDTH-1]}}, prod_ff};

   always_comb begin
      if (acc_wide[ACC_WIDTH] != acc_wide[ACC_WIDTH-1]) begin
         acc_sat = acc_wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_sat = acc_wide[ACC_WIDTH-1:0];
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_update) begin
         acc_in = ctrl.last ? '0 : acc_sat;
      end
   end

   assign sum_in = acc_sat;

   // stage d: scale by the reciprocal
   assign scaled_in = sum_ff * $signed({1'b0, stxyz_pkg::INV_YINT_Q16});

   // stage e: round half up to Q.16, saturate to the output range
   assign rounded   = scaled_ff + ROUND_BIAS;
   assign quot      = rounded[SCALED_WIDTH-1:stxyz_pkg::ROUND_SHIFT];
   assign quot_fits = (&quot[QUOT_WIDTH-1:OUT_WIDTH-1]) | ~(|quot[QUOT_WIDTH-1:OUT_WIDTH-1]);

   always_comb begin
      if (quot_fits) begin
         out_in = quot[OUT_WIDTH-1:0];
      end else begin
         out_in = quot[QUOT_WIDTH-1] ? OUT_MIN : OUT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.b_load) begin
         prod_ff <= prod_in;
      end
      if (ctrl.c_load) begin
         sum_ff <= sum_in;
      end
      if (ctrl.d_load) begin
         scaled_ff <= scaled_in;
      end
      if (ctrl.e_load) begin
         out_ff <= out_in;
      end
   end

   assign result = out_ff;

endmodule
